[rtl/core/rk4cf_pkg.sv]
// rk4cf_pkg: shared constants and types for the constant-force rk4 step
// no dependencies
package rk4cf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;
  localparam int DW        = 32;
  localparam int DVD_W     = DW + FRAC_BITS;
  localparam int DIV_LAT   = DVD_W + 1;
  localparam int TAIL_LAT  = 4;
  localparam int LAT       = DIV_LAT + TAIL_LAT;
  localparam int PROD_W    = DW + DT_BITS;
  localparam int SUM_W     = DW + 2;
  localparam int IN_W      = 336;
  localparam int OUT_W     = 200;

  localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] S32_MIN = -SUM_W'(64'sd2147483648);

  typedef struct packed {
    logic [2:0][DW-1:0]      pos;
    logic [2:0][DW-1:0]      vel;
    logic [DT_BITS-1:0]      dt;
    logic                    zm;
  } side_t;

endpackage

[rtl/core/rk4_constant_force_step.sv]
// rk4_constant_force_step: top level, stream ports, valid chain and payload delay line
// depends on rk4cf_pkg, rk4cf_div, rk4cf_tail
// One body enters and one result leaves per cycle while the pipeline advances.
// 49 stages of the restoring divider for force/mass (a load stage, then one quotient
// bit per stage, 48-bit dividend) and 4 stages for acceleration clipping, the dt
// products and the final saturating sums. The whole pipeline advances when the output
// register is empty or being taken; s_tready follows that condition.
module rk4_constant_force_step import rk4cf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z,
  // body_mass, step_time
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
  // zero_mass, saturated, zero padding
  output logic [OUT_W-1:0]  m_tdata
);

  logic                 ce;
  logic [LAT-1:0]       vld;
  side_t                side [0:DIV_LAT-1];
  side_t                side_in;
  logic [2:0][DW-1:0]   fmag;
  logic [2:0]           fneg;
  logic [DW-1:0]        mass;
  logic [2:0][DVD_W-1:0] quo;
  logic [2:0]           qneg;
  logic [2:0][DW-1:0]   npos, nvel;
  logic [2:0]           sat;
  logic [TAIL_LAT-1:0]  zm_d;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[LAT-1];

  always_comb begin
    logic [DW-1:0] f;
    for (int l = 0; l < 3; l++) begin
      side_in.pos[l] = s_tdata[l*DW +: DW];
      side_in.vel[l] = s_tdata[(3+l)*DW +: DW];
      f              = s_tdata[(6+l)*DW +: DW];
      fneg[l]        = f[DW-1];
      fmag[l]        = f[DW-1] ? DW'(-f) : f;
    end
    mass       = s_tdata[9*DW +: DW];
    side_in.dt = s_tdata[10*DW +: DT_BITS];
    side_in.zm = (mass == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0] <= side_in;
      for (int i = 1; i < DIV_LAT; i++) side[i] <= side[i-1];
      zm_d <= {zm_d[TAIL_LAT-2:0], side[DIV_LAT-1].zm};
    end
  end

  rk4cf_div u_div (
    .clk  (clk),
    .ce   (ce),
    .fmag (fmag),
    .fneg (fneg),
    .mass (mass),
    .quo  (quo),
    .neg  (qneg)
  );

  for (genvar l = 0; l < 3; l++) begin : g_axis
    rk4cf_tail u_tail (
      .clk     (clk),
      .rst     (rst),
      .ce      (ce),
      .quo     (quo[l]),
      .fneg    (qneg[l]),
      .pos     (side[DIV_LAT-1].pos[l]),
      .vel     (side[DIV_LAT-1].vel[l]),
      .dt      (side[DIV_LAT-1].dt),
      .zm      (side[DIV_LAT-1].zm),
      .new_pos (npos[l]),
      .new_vel (nvel[l]),
      .sat     (sat[l])
    );
  end

  assign m_tdata = {6'b0, |sat, zm_d[TAIL_LAT-1],
                    nvel[2], nvel[1], nvel[0], npos[2], npos[1], npos[0]};

endmodule

[rtl/core/rk4cf_div.sv]
// rk4cf_div: three-lane restoring divider, one quotient bit per pipeline stage
// depends on rk4cf_pkg
module rk4cf_div import rk4cf_pkg::*; (
  input  logic                        clk,
  input  logic                        ce,
  input  logic [2:0][DW-1:0]          fmag,
  input  logic [2:0]                  fneg,
  input  logic [DW-1:0]               mass,
  output logic [2:0][DVD_W-1:0]       quo,
  output logic [2:0]                  neg
);

  logic [DW-1:0]                mass_q [0:DVD_W];
  logic [2:0]                   neg_q  [0:DVD_W];
  logic [2:0][DW-1:0]           rem_q  [0:DVD_W];
  logic [2:0][DVD_W-1:0]        dq_q   [0:DVD_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      mass_q[0] <= mass;
      neg_q[0]  <= fneg;
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= '0;
        dq_q[0][l]  <= {fmag[l], {FRAC_BITS{1'b0}}};
      end
    end
  end

  for (genvar k = 0; k < DVD_W; k++) begin : g_step
    logic [2:0][DW-1:0]    rem_next;
    logic [2:0][DVD_W-1:0] dq_next;

    always_comb begin
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;
      for (int l = 0; l < 3; l++) begin
        trial       = {rem_q[k][l], dq_q[k][l][DVD_W-1]};
        diff        = trial - {1'b0, mass_q[k]};
        ge          = trial >= {1'b0, mass_q[k]};
        rem_next[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
        dq_next[l]  = {dq_q[k][l][DVD_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        mass_q[k+1] <= mass_q[k];
        neg_q[k+1]  <= neg_q[k];
        rem_q[k+1]  <= rem_next;
        dq_q[k+1]   <= dq_next;
      end
    end
  end

  assign quo = dq_q[DVD_W];
  assign neg = neg_q[DVD_W];

endmodule

[rtl/core/rk4cf_tail.sv]
// rk4cf_tail: one axis after the divide: accel clip, products, sums and clip
// depends on rk4cf_pkg
module rk4cf_tail import rk4cf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic [DVD_W-1:0]      quo,
  input  logic                  fneg,
  input  logic [DW-1:0]         pos,
  input  logic [DW-1:0]         vel,
  input  logic [DT_BITS-1:0]    dt,
  input  logic                  zm,
  output logic [DW-1:0]         new_pos,
  output logic [DW-1:0]         new_vel,
  output logic                  sat
);

  // stage a
  logic [DW-1:0]      am_a, vm_a, pos_a, vel_a;
  logic               an_a, vn_a, asat_a, zm_a;
  logic [DT_BITS-1:0] dt_a;
  // stage b
  logic [PROD_W-1:0]  amdt_b, vdt_b;
  logic [DW-1:0]      pos_b, vel_b;
  logic               an_b, vn_b, asat_b, zm_b;
  logic [DT_BITS-1:0] dt_b;
  // stage c
  logic [DW-1:0]      dvm_c, p1m_c, p2m_c, pos_c, vel_c;
  logic               an_c, vn_c, asat_c, zm_c;

  logic [DVD_W-1:0]   lim;
  logic [PROD_W+DT_BITS-1:0] amdt2;
  logic signed [SUM_W-1:0] dvs, p1s, p2s, sumv, sumx;

  assign lim   = fneg ? DVD_W'(64'h8000_0000) : DVD_W'(64'h7fff_ffff);
  assign amdt2 = (PROD_W+DT_BITS)'(amdt_b) * (PROD_W+DT_BITS)'(dt_b);

  always_ff @(posedge clk) begin
    if (ce) begin
      zm_a  <= zm;
      an_a  <= fneg;
      vn_a  <= vel[DW-1];
      vm_a  <= vel[DW-1] ? DW'(-vel) : vel;
      pos_a <= pos;
      vel_a <= vel;
      dt_a  <= dt;
      if (zm) begin
        am_a   <= '0;
        asat_a <= 1'b0;
      end else if (quo > lim) begin
        am_a   <= lim[DW-1:0];
        asat_a <= 1'b1;
      end else begin
        am_a   <= quo[DW-1:0];
        asat_a <= 1'b0;
      end

      amdt_b <= PROD_W'(am_a) * PROD_W'(dt_a);
      vdt_b  <= PROD_W'(vm_a) * PROD_W'(dt_a);
      an_b   <= an_a;
      vn_b   <= vn_a;
      asat_b <= asat_a;
      zm_b   <= zm_a;
      pos_b  <= pos_a;
      vel_b  <= vel_a;
      dt_b   <= dt_a;

      dvm_c  <= amdt_b[PROD_W-1:DT_BITS];
      p1m_c  <= vdt_b[PROD_W-1:DT_BITS];
      p2m_c  <= DW'(amdt2 >> (2*DT_BITS + 1));
      an_c   <= an_b;
      vn_c   <= vn_b;
      asat_c <= asat_b;
      zm_c   <= zm_b;
      pos_c  <= pos_b;
      vel_c  <= vel_b;
    end
  end

  always_comb begin
    dvs  = an_c ? -$signed({2'b00, dvm_c}) : $signed({2'b00, dvm_c});
    p1s  = vn_c ? -$signed({2'b00, p1m_c}) : $signed({2'b00, p1m_c});
    p2s  = an_c ? -$signed({2'b00, p2m_c}) : $signed({2'b00, p2m_c});
    sumv = $signed({{2{vel_c[DW-1]}}, vel_c}) + dvs;
    sumx = $signed({{2{pos_c[DW-1]}}, pos_c}) + p1s + p2s;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sat <= asat_c || sumv > S32_MAX || sumv < S32_MIN
             || sumx > S32_MAX || sumx < S32_MIN;
      if (sumv > S32_MAX)      new_vel <= S32_MAX[DW-1:0];
      else if (sumv < S32_MIN) new_vel <= S32_MIN[DW-1:0];
      else                     new_vel <= sumv[DW-1:0];
      if (sumx > S32_MAX)      new_pos <= S32_MAX[DW-1:0];
      else if (sumx < S32_MIN) new_pos <= S32_MIN[DW-1:0];
      else                     new_pos <= sumx[DW-1:0];
    end
  end

  a_zero_mass_accel: assert property (@(posedge clk) disable iff (rst)
    zm_a |-> (am_a == '0 && !asat_a))
    else $error("zero mass left nonzero acceleration");
  a_zero_mass_terms: assert property (@(posedge clk) disable iff (rst)
    zm_c |-> (dvm_c == '0 && p2m_c == '0 && !asat_c))
    else $error("zero mass left acceleration terms");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !ce |=> ($stable(new_pos) && $stable(new_vel) && $stable(sat)))
    else $error("result changed during stall");

endmodule

[test/tb.sv]
// tb: self-checking testbench for rk4_constant_force_step
// drives random and corner bodies, predicts each result in fixed point, checks in order
// depends on rk4cf_pkg and rk4_constant_force_step
`timescale 1ns / 1ps
module tb;
  import rk4cf_pkg::*;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic signed [31:0] frc [3];
    logic [31:0] mass;
    logic [15:0] dt;
  } body_t;

  typedef struct {
    logic [31:0] npos [3];
    logic [31:0] nvel [3];
    logic zm;
    logic sat;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  rk4_constant_force_step u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  body_t pending_bodies[$];
  update_t expected_updates[$];
  int mismatches = 0;
  bit stim_done = 0;
  bit hold_sink = 0;
  bit wait_drain = 0;
  int send_gap = 0;
  int sink_gap = 0;
  int sent = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] pack_body(body_t b);
    logic [IN_W-1:0] d;
    d = '0;
    for (int k = 0; k < 3; k++) begin
      d[32*k +: 32] = b.pos[k];
      d[96 + 32*k +: 32] = b.vel[k];
      d[192 + 32*k +: 32] = b.frc[k];
    end
    d[288 +: 32] = b.mass;
    d[320 +: 16] = b.dt;
    return d;
  endfunction

  function automatic logic signed [33:0] clip_sum(logic signed [65:0] v, inout bit sat);
    if (v > 66'sd2147483647) begin
      sat = 1;
      return 34'sd2147483647;
    end
    if (v < -66'sd2147483648) begin
      sat = 1;
      return -34'sd2147483648;
    end
    return v[33:0];
  endfunction

  function automatic update_t integrate_body(body_t b);
    update_t u;
    bit sat;
    logic [63:0] fm, q, am, vm;
    logic signed [65:0] acc, dv, p1, p2, s;
    logic signed [33:0] c;
    bit an, vn;
    sat = 0;
    for (int k = 0; k < 3; k++) begin
      if (b.mass == 0) begin
        acc = 0;
      end else begin
        fm = b.frc[k] < 0 ? 64'(-$signed(66'(b.frc[k]))) : 64'(b.frc[k]);
        q = (fm << FRAC_BITS) / 64'(b.mass);
        if (b.frc[k] >= 0) begin
          if (q > 64'd2147483647) begin
            sat = 1;
            q = 64'd2147483647;
          end
          acc = $signed({2'b0, q});
        end else begin
          if (q > 64'h80000000) begin
            sat = 1;
            q = 64'h80000000;
          end
          acc = -$signed({2'b0, q});
        end
      end
      an = acc < 0;
      vn = b.vel[k] < 0;
      am = an ? 64'(-acc) : 64'(acc);
      vm = vn ? 64'(-$signed(66'(b.vel[k]))) : 64'(b.vel[k]);
      dv = $signed({2'b0, (am * b.dt) >> 16});
      p1 = $signed({2'b0, (vm * b.dt) >> 16});
      p2 = $signed({2'b0, ((am * b.dt) * b.dt) >> 33});
      if (an) begin
        dv = -dv;
        p2 = -p2;
      end
      if (vn) p1 = -p1;
      s = 66'(b.vel[k]) + dv;
      c = clip_sum(s, sat);
      u.nvel[k] = c[31:0];
      s = 66'(b.pos[k]) + p1 + p2;
      c = clip_sum(s, sat);
      u.npos[k] = c[31:0];
    end
    u.zm = b.mass == 0;
    u.sat = sat;
    return u;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic body_t rand_body();
    body_t b;
    for (int k = 0; k < 3; k++) begin
      b.pos[k] = rand_word();
      b.vel[k] = rand_word();
      b.frc[k] = rand_word();
    end
    case ($urandom_range(0, 5))
      0: b.mass = 0;
      1: b.mass = $urandom_range(1, 255);
      2: b.mass = 32'hffffffff;
      3: b.mass = 32'h00010000;
      default: b.mass = $urandom;
    endcase
    b.dt = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
    return b;
  endfunction

  initial begin
    body_t b;
    logic [31:0] ext [4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < 3; k++) begin
        b.pos[k] = ext[(i + k) % 4];
        b.vel[k] = ext[(i / 4 + k) % 4];
        b.frc[k] = ext[(i + 2 * k) % 4];
      end
      b.mass = (i % 4 == 0) ? 32'h0 : (i % 4 == 1) ? 32'h1 : (i % 4 == 2) ? 32'hffffffff
             : 32'h00010000;
      b.dt = (i % 3 == 0) ? 16'h0 : (i % 3 == 1) ? 16'hffff : 16'h8000;
      pending_bodies.push_back(b);
    end
    for (int i = 0; i < 1300; i++) pending_bodies.push_back(rand_body());
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (sent == 300);
    hold_sink = 1;
    repeat (200) @(posedge clk);
    hold_sink = 0;
  end

  // sender pause until the pipeline drains
  initial begin
    wait (sent == 700);
    wait_drain = 1;
    wait (expected_updates.size() == 0);
    @(posedge clk);
    wait_drain = 0;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    int gap;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sent <= sent + 1;
        gap = $urandom_range(0, 8);
      end else begin
        gap = send_gap;
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered transaction
      end else if (gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= gap - 1;
      end else if (!wait_drain && pending_bodies.size() > 0) begin
        b_send();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  task automatic b_send();
    body_t b;
    b = pending_bodies.pop_front();
    expected_updates.push_back(integrate_body(b));
    s_tdata <= pack_body(b);
    s_tvalid <= 1'b1;
  endtask

  always @(posedge clk) begin
    update_t e;
    bit bad;
    int gap;
    cycles <= cycles + 1;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_updates.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected transaction %h", m_tdata);
        end else begin
          e = expected_updates.pop_front();
          bad = 0;
          for (int k = 0; k < 3; k++) begin
            if (m_tdata[32*k +: 32] !== e.npos[k]) bad = 1;
            if (m_tdata[96 + 32*k +: 32] !== e.nvel[k]) bad = 1;
          end
          if (m_tdata[192] !== e.zm || m_tdata[193] !== e.sat) bad = 1;
          if (bad) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp pos %h %h %h vel %h %h %h zm %b sat %b, got %h",
                       e.npos[0], e.npos[1], e.npos[2], e.nvel[0], e.nvel[1], e.nvel[2],
                       e.zm, e.sat, m_tdata[193:0]);
          end
        end
        gap = $urandom_range(0, 8);
        if (gap == 0 && !hold_sink) begin
          m_tready <= 1'b1;
        end else begin
          sink_gap <= (gap > 0) ? gap - 1 : 0;
          m_tready <= 1'b0;
        end
      end else if (hold_sink) begin
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (!rst && pending_bodies.size() == 0 && !s_tvalid);
    wait (expected_updates.size() == 0);
    repeat (LAT + 20) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    wait (cycles == 200000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
